/* src/r2fft_pkg.sv */
`timescale 1ns / 1ps
package r2fft_pkg;

  localparam int MAX_LOG_POINTS = 6;
  localparam int ADDR_W         = MAX_LOG_POINTS;
  localparam int LOG_W          = 3;
  localparam int TW_W           = 16;
  localparam int TW_FRAC        = 15;
  localparam int CFG_ADDR_W     = 1;
  localparam int CFG_DATA_W     = 3;

  // register indexes on the configuration port
  localparam logic [CFG_ADDR_W-1:0] CFG_INVERSE_MODE = 1'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_LOG_POINTS   = 1'd1;

  // controller to datapath commands
  typedef struct packed {
    logic              load_we;
    logic [ADDR_W-1:0] load_addr;
    logic              bf_issue;
    logic [ADDR_W-1:0] bf_elem;
    logic [LOG_W-1:0]  stage;
    logic [LOG_W-1:0]  log_len;
    logic              inv;
    logic              out_issue;
    logic [ADDR_W-1:0] out_idx;
    logic              out_last;
  } r2fft_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic pipe_busy;
    logic out_space;
  } r2fft_sts_t;

  // Q1.15 cosine over a quarter turn, 16 steps of 2*pi/64
  function automatic logic signed [TW_W-1:0] tw_quarter(input logic [4:0] idx);
    logic signed [TW_W-1:0] v;
    unique case (idx)
      5'd0:  v = 16'sd32767;
      5'd1:  v = 16'sd32610;
      5'd2:  v = 16'sd32138;
      5'd3:  v = 16'sd31357;
      5'd4:  v = 16'sd30274;
      5'd5:  v = 16'sd28899;
      5'd6:  v = 16'sd27246;
      5'd7:  v = 16'sd25330;
      5'd8:  v = 16'sd23170;
      5'd9:  v = 16'sd20788;
      5'd10: v = 16'sd18205;
      5'd11: v = 16'sd15447;
      5'd12: v = 16'sd12540;
      5'd13: v = 16'sd9512;
      5'd14: v = 16'sd6393;
      5'd15: v = 16'sd3212;
      default: v = 16'sd0;
    endcase
    return v;
  endfunction

  // returns {sin, cos} of 2*pi*m/64
  function automatic logic [2*TW_W-1:0] twiddle(input logic [ADDR_W-1:0] m);
    logic [1:0]             quad;
    logic [4:0]             r;
    logic signed [TW_W-1:0] cm;
    logic signed [TW_W-1:0] sm;
    logic signed [TW_W-1:0] c;
    logic signed [TW_W-1:0] s;
    quad = m[ADDR_W-1 -: 2];
    r    = {1'b0, m[ADDR_W-3:0]};
    cm   = tw_quarter(r);
    sm   = tw_quarter(5'd16 - r);
    unique case (quad)
      2'd0: begin c = cm;  s = sm;  end
      2'd1: begin c = -sm; s = cm;  end
      2'd2: begin c = -cm; s = -sm; end
      default: begin c = sm; s = -cm; end
    endcase
    return {s, c};
  endfunction

endpackage

/* src/r2fft_ram.sv */
`timescale 1ns / 1ps
module r2fft_ram #(
  parameter int WIDTH = 44,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr0,
  input  logic [$clog2(DEPTH)-1:0] raddr1,
  output logic [WIDTH-1:0]         rdata0,
  output logic [WIDTH-1:0]         rdata1
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata0 <= mem[raddr0];
    rdata1 <= mem[raddr1];
  end

endmodule

/* src/r2fft_ctrl.sv */
`timescale 1ns / 1ps
module r2fft_ctrl import r2fft_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic                  cfg_we,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  r2fft_sts_t            sts,
  output r2fft_cmd_t            cmd
);

  localparam logic [1:0] ST_LOAD  = 2'd0;
  localparam logic [1:0] ST_RUN   = 2'd1;
  localparam logic [1:0] ST_DRAIN = 2'd2;
  localparam logic [1:0] ST_EMIT  = 2'd3;

  logic [1:0]        state_r, state_nxt;
  logic [ADDR_W:0]   cnt_r, cnt_nxt;
  logic [LOG_W-1:0]  stage_r, stage_nxt;
  logic              inv_mode_r, inv_mode_nxt;
  logic [LOG_W-1:0]  log_r, log_nxt;
  logic              run_inv_r, run_inv_nxt;
  logic [LOG_W-1:0]  eff_log;
  logic [ADDR_W:0]   last_idx;
  logic              accept;
  logic              at_last;

  // clamp the length register into the supported range
  always_comb begin
    priority if (log_r == '0) begin
      eff_log = LOG_W'(1);
    end else if (log_r > LOG_W'(MAX_LOG_POINTS)) begin
      eff_log = LOG_W'(MAX_LOG_POINTS);
    end else begin
      eff_log = log_r;
    end
  end

  assign last_idx  = ((ADDR_W+1)'(1) << eff_log) - (ADDR_W+1)'(1);
  assign at_last   = (cnt_r == last_idx);
  assign in_tready = (state_r == ST_LOAD);
  assign accept    = in_tvalid & in_tready;

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    stage_nxt     = stage_r;
    inv_mode_nxt  = inv_mode_r;
    log_nxt       = log_r;
    run_inv_nxt   = run_inv_r;
    cmd           = '0;
    cmd.load_addr = cnt_r[ADDR_W-1:0];
    cmd.bf_elem   = cnt_r[ADDR_W-1:0];
    cmd.out_idx   = cnt_r[ADDR_W-1:0];
    cmd.out_last  = at_last;
    cmd.stage     = stage_r;
    cmd.log_len   = eff_log;
    cmd.inv       = run_inv_r;

    unique case (state_r)
      ST_LOAD: begin
        if (accept) begin
          cmd.load_we = 1'b1;
          if (at_last) begin
            cnt_nxt     = '0;
            stage_nxt   = '0;
            run_inv_nxt = inv_mode_r;
            state_nxt   = ST_RUN;
          end else begin
            cnt_nxt = cnt_r + (ADDR_W+1)'(1);
          end
        end
      end
      ST_RUN: begin
        cmd.bf_issue = 1'b1;
        if (at_last) begin
          cnt_nxt   = '0;
          state_nxt = ST_DRAIN;
        end else begin
          cnt_nxt = cnt_r + (ADDR_W+1)'(1);
        end
      end
      ST_DRAIN: begin
        // wait for the last writes of the stage to land
        if (!sts.pipe_busy) begin
          if (stage_r == eff_log - LOG_W'(1)) begin
            state_nxt = ST_EMIT;
          end else begin
            stage_nxt = stage_r + LOG_W'(1);
            state_nxt = ST_RUN;
          end
        end
      end
      ST_EMIT: begin
        if (sts.out_space) begin
          cmd.out_issue = 1'b1;
          if (at_last) begin
            cnt_nxt   = '0;
            state_nxt = ST_LOAD;
          end else begin
            cnt_nxt = cnt_r + (ADDR_W+1)'(1);
          end
        end
      end
      default: state_nxt = ST_LOAD;
    endcase

    if (cfg_we) begin
      if (cfg_addr == CFG_INVERSE_MODE) begin
        inv_mode_nxt = cfg_wdata[0];
      end else begin
        log_nxt = cfg_wdata;
        cnt_nxt = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_LOAD;
      cnt_r      <= '0;
      stage_r    <= '0;
      inv_mode_r <= 1'b0;
      log_r      <= LOG_W'(MAX_LOG_POINTS);
      run_inv_r  <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      cnt_r      <= cnt_nxt;
      stage_r    <= stage_nxt;
      inv_mode_r <= inv_mode_nxt;
      log_r      <= log_nxt;
      run_inv_r  <= run_inv_nxt;
    end
  end

endmodule

/* src/r2fft_dp.sv */
`timescale 1ns / 1ps
module r2fft_dp import r2fft_pkg::*; #(
  parameter int SAMPLE_WIDTH = 16
) (
  input  logic                                             clk,
  input  logic                                             rst_n,
  input  r2fft_cmd_t                                       cmd,
  output r2fft_sts_t                                       sts,
  input  logic signed [SAMPLE_WIDTH-1:0]                   sample_real,
  input  logic signed [SAMPLE_WIDTH-1:0]                   sample_imag,
  output logic                                             out_valid,
  input  logic                                             out_ready,
  output logic signed [SAMPLE_WIDTH+MAX_LOG_POINTS-1:0]    bin_real,
  output logic signed [SAMPLE_WIDTH+MAX_LOG_POINTS-1:0]    bin_imag,
  output logic                                             last_bin
);

  localparam int ACC_W = SAMPLE_WIDTH + MAX_LOG_POINTS;
  localparam int ENT_W = 2 * ACC_W;
  localparam int DW    = ACC_W + 1;
  localparam int PW    = DW + TW_W;
  localparam int SW2   = PW + 1;
  localparam int RND_W = SW2 - TW_FRAC;

  localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
  localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

  function automatic logic signed [ACC_W-1:0] sat_sum(input logic signed [DW-1:0] v);
    logic signed [ACC_W-1:0] r;
    if (v[DW-1] != v[DW-2]) begin
      r = v[DW-1] ? ACC_MIN : ACC_MAX;
    end else begin
      r = v[ACC_W-1:0];
    end
    return r;
  endfunction

  function automatic logic signed [ACC_W-1:0] sat_rnd(input logic signed [RND_W-1:0] v);
    logic [RND_W-ACC_W:0]    hi;
    logic signed [ACC_W-1:0] r;
    hi = v[RND_W-1:ACC_W-1];
    if (hi == '0 || hi == '1) begin
      r = v[ACC_W-1:0];
    end else begin
      r = v[RND_W-1] ? ACC_MIN : ACC_MAX;
    end
    return r;
  endfunction

  // ---------------- issue: addresses and twiddle index
  logic [LOG_W-1:0]  pos;
  logic [LOG_W-1:0]  tw_sh;
  logic [LOG_W-1:0]  rev_sh;
  logic [ADDR_W-1:0] half;
  logic [ADDR_W-1:0] addr_a;
  logic [ADDR_W-1:0] addr_b;
  logic [ADDR_W-1:0] tw_idx;
  logic [ADDR_W-1:0] rev;
  logic [ADDR_W-1:0] out_addr;
  logic              is_top;

  always_comb begin
    pos    = cmd.log_len - cmd.stage - LOG_W'(1);
    half   = ADDR_W'(1) << pos;
    addr_a = cmd.bf_elem & ~half;
    addr_b = cmd.bf_elem | half;
    is_top = ((cmd.bf_elem & half) == '0);
    tw_sh  = cmd.stage + LOG_W'(MAX_LOG_POINTS) - cmd.log_len;
    tw_idx = (cmd.bf_elem & (half - ADDR_W'(1))) << tw_sh;
    for (int b = 0; b < ADDR_W; b++) begin
      rev[ADDR_W-1-b] = cmd.out_idx[b];
    end
    rev_sh   = LOG_W'(MAX_LOG_POINTS) - cmd.log_len;
    out_addr = rev >> rev_sh;
  end

  // ---------------- buffers
  logic [ADDR_W-1:0] raddr0;
  logic [ENT_W-1:0]  rd0_a, rd1_a, rd0_b, rd1_b;
  logic              wa_we, wb_we;
  logic [ADDR_W-1:0] wa_addr;
  logic [ENT_W-1:0]  wa_data;
  logic [ENT_W-1:0]  load_data;
  logic [ENT_W-1:0]  bf_data;

  assign raddr0 = cmd.bf_issue ? addr_a : out_addr;

  // ---------------- pipeline registers
  logic                    p1_v_r, p1_top_r, p1_srcb_r;
  logic [ADDR_W-1:0]       p1_addr_r, p1_tw_r;
  logic                    p2_v_r, p2_top_r, p2_dstb_r;
  logic [ADDR_W-1:0]       p2_addr_r;
  logic signed [ACC_W-1:0] p2_sr_r, p2_si_r;
  logic signed [DW-1:0]    p2_dr_r, p2_di_r;
  logic signed [TW_W-1:0]  p2_wr_r, p2_wi_r;
  logic                    p3_v_r, p3_top_r, p3_dstb_r;
  logic [ADDR_W-1:0]       p3_addr_r;
  logic signed [ACC_W-1:0] p3_sr_r, p3_si_r;
  logic signed [PW-1:0]    p3_rr_r, p3_ii_r, p3_ri_r, p3_ir_r;

  // ---------------- stage 1: sum, difference, twiddle
  logic [ENT_W-1:0]        src0, src1;
  logic signed [ACC_W-1:0] a_re, a_im, b_re, b_im;
  logic signed [DW-1:0]    sum_re, sum_im, dif_re, dif_im;
  logic [2*TW_W-1:0]       tw;
  logic signed [TW_W-1:0]  tw_c, tw_s, tw_wi;

  always_comb begin
    src0   = p1_srcb_r ? rd0_b : rd0_a;
    src1   = p1_srcb_r ? rd1_b : rd1_a;
    a_re   = src0[ACC_W-1:0];
    a_im   = src0[ENT_W-1:ACC_W];
    b_re   = src1[ACC_W-1:0];
    b_im   = src1[ENT_W-1:ACC_W];
    sum_re = DW'(a_re) + DW'(b_re);
    sum_im = DW'(a_im) + DW'(b_im);
    dif_re = DW'(a_re) - DW'(b_re);
    dif_im = DW'(a_im) - DW'(b_im);
    tw     = twiddle(p1_tw_r);
    tw_c   = tw[TW_W-1:0];
    tw_s   = tw[2*TW_W-1:TW_W];
    // conjugate for the forward transform
    tw_wi  = cmd.inv ? tw_s : -tw_s;
  end

  // ---------------- stage 3: combine products, round, saturate
  logic signed [SW2-1:0]   pr, pim;
  logic signed [SW2-1:0]   pr_rnd, pim_rnd;
  logic signed [ACC_W-1:0] q_re, q_im;

  always_comb begin
    pr      = SW2'(p3_rr_r) - SW2'(p3_ii_r);
    pim     = SW2'(p3_ri_r) + SW2'(p3_ir_r);
    pr_rnd  = (pr + (SW2'(1) << (TW_FRAC - 1))) >>> TW_FRAC;
    pim_rnd = (pim + (SW2'(1) << (TW_FRAC - 1))) >>> TW_FRAC;
    q_re    = sat_rnd(pr_rnd[RND_W-1:0]);
    q_im    = sat_rnd(pim_rnd[RND_W-1:0]);
    bf_data = p3_top_r ? {p3_si_r, p3_sr_r} : {q_im, q_re};
  end

  assign load_data = {ACC_W'(sample_imag), ACC_W'(sample_real)};
  assign wa_we     = cmd.load_we | (p3_v_r & ~p3_dstb_r);
  assign wa_addr   = cmd.load_we ? cmd.load_addr : p3_addr_r;
  assign wa_data   = cmd.load_we ? load_data : bf_data;
  assign wb_we     = p3_v_r & p3_dstb_r;

  r2fft_ram #(.WIDTH(ENT_W), .DEPTH(1 << ADDR_W)) u_ram_a (
    .clk    (clk),
    .we     (wa_we),
    .waddr  (wa_addr),
    .wdata  (wa_data),
    .raddr0 (raddr0),
    .raddr1 (addr_b),
    .rdata0 (rd0_a),
    .rdata1 (rd1_a)
  );

  r2fft_ram #(.WIDTH(ENT_W), .DEPTH(1 << ADDR_W)) u_ram_b (
    .clk    (clk),
    .we     (wb_we),
    .waddr  (p3_addr_r),
    .wdata  (bf_data),
    .raddr0 (raddr0),
    .raddr1 (addr_b),
    .rdata0 (rd0_b),
    .rdata1 (rd1_b)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_v_r <= 1'b0;
      p2_v_r <= 1'b0;
      p3_v_r <= 1'b0;
    end else begin
      p1_v_r <= cmd.bf_issue;
      p2_v_r <= p1_v_r;
      p3_v_r <= p2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    p1_top_r  <= is_top;
    p1_srcb_r <= cmd.stage[0];
    p1_addr_r <= cmd.bf_elem;
    p1_tw_r   <= tw_idx;

    p2_top_r  <= p1_top_r;
    p2_dstb_r <= ~p1_srcb_r;
    p2_addr_r <= p1_addr_r;
    p2_sr_r   <= sat_sum(sum_re);
    p2_si_r   <= sat_sum(sum_im);
    p2_dr_r   <= dif_re;
    p2_di_r   <= dif_im;
    p2_wr_r   <= tw_c;
    p2_wi_r   <= tw_wi;

    p3_top_r  <= p2_top_r;
    p3_dstb_r <= p2_dstb_r;
    p3_addr_r <= p2_addr_r;
    p3_sr_r   <= p2_sr_r;
    p3_si_r   <= p2_si_r;
    p3_rr_r   <= p2_dr_r * p2_wr_r;
    p3_ii_r   <= p2_di_r * p2_wi_r;
    p3_ri_r   <= p2_dr_r * p2_wi_r;
    p3_ir_r   <= p2_di_r * p2_wr_r;
  end

  // ---------------- result read-out with inverse scaling and a 2-entry queue
  logic                    rd_v_r, rd_last_r, rd_srcb_r;
  logic [ENT_W-1:0]        rd_ent;
  logic signed [DW-1:0]    rnd_bias;
  logic signed [DW-1:0]    sc_re, sc_im;
  logic signed [ACC_W-1:0] res_re, res_im;
  logic signed [ACC_W-1:0] fq_re_r [2];
  logic signed [ACC_W-1:0] fq_im_r [2];
  logic                    fq_last_r [2];
  logic                    wp_r, rp_r;
  logic [1:0]              fcnt_r, fcnt_nxt;
  logic                    pop;

  always_comb begin
    rd_ent   = rd_srcb_r ? rd0_b : rd0_a;
    rnd_bias = DW'(1) << (cmd.log_len - LOG_W'(1));
    sc_re    = (DW'($signed(rd_ent[ACC_W-1:0])) + rnd_bias) >>> cmd.log_len;
    sc_im    = (DW'($signed(rd_ent[ENT_W-1:ACC_W])) + rnd_bias) >>> cmd.log_len;
    res_re   = cmd.inv ? sc_re[ACC_W-1:0] : rd_ent[ACC_W-1:0];
    res_im   = cmd.inv ? sc_im[ACC_W-1:0] : rd_ent[ENT_W-1:ACC_W];
  end

  assign out_valid = (fcnt_r != 2'd0);
  assign pop       = out_valid & out_ready;
  assign bin_real  = fq_re_r[rp_r];
  assign bin_imag  = fq_im_r[rp_r];
  assign last_bin  = fq_last_r[rp_r];
  assign fcnt_nxt  = fcnt_r + {1'b0, rd_v_r} - {1'b0, pop};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_v_r <= 1'b0;
      wp_r   <= 1'b0;
      rp_r   <= 1'b0;
      fcnt_r <= 2'd0;
    end else begin
      rd_v_r <= cmd.out_issue;
      fcnt_r <= fcnt_nxt;
      if (rd_v_r) begin
        wp_r <= ~wp_r;
      end
      if (pop) begin
        rp_r <= ~rp_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    rd_last_r <= cmd.out_last;
    rd_srcb_r <= cmd.log_len[0];
    if (rd_v_r) begin
      fq_re_r[wp_r]   <= res_re;
      fq_im_r[wp_r]   <= res_im;
      fq_last_r[wp_r] <= rd_last_r;
    end
  end

  assign sts.pipe_busy = p1_v_r | p2_v_r | p3_v_r;
  assign sts.out_space = ({1'b0, fcnt_r} + {2'b0, rd_v_r}) <= ({2'b0, pop} + 3'd1);

endmodule

/* src/radix2_dif_fft_with_inverse.sv */
`timescale 1ns / 1ps
// Radix-2 decimation-in-frequency FFT with optional inverse.
//
// Input stream (in_*): one complex time sample per item. Output stream (out_*):
// one frequency bin per item, in natural order, out_tlast on the final bin.
// Configuration (cfg_*): register 0 selects the inverse transform with 1/N
// rounding scale, register 1 sets log2 of the length (1..6, others clamp).
// Writing register 1 restarts the frame being collected.
//
// A frame of N = 2^L samples is taken one per cycle while in_tready is high.
// After the last sample, in_tready drops and the block runs L stages with one
// output point of a butterfly pair per cycle: the single write port of each
// ping-pong buffer sets that rate, and the butterfly pipeline drains before
// the next stage starts. The N bins then leave at up to one per cycle through
// a bit-reversed read.
//
// A stalled receiver holds the read-out: a two-entry queue absorbs the
// registered memory read, and no read is issued without space. After reset the
// block waits for the first sample with forward mode and length 64.
module radix2_dif_fft_with_inverse import r2fft_pkg::*; #(
  parameter int SAMPLE_WIDTH = 16
) (
  input  logic                                                 clk,
  input  logic                                                 rst_n,
  // sample_real, sample_imag
  input  logic [((2*SAMPLE_WIDTH+7)/8)*8-1:0]                  in_tdata,
  input  logic                                                 in_tvalid,
  output logic                                                 in_tready,
  // bin_real, bin_imag
  output logic [((2*(SAMPLE_WIDTH+MAX_LOG_POINTS)+7)/8)*8-1:0] out_tdata,
  output logic                                                 out_tlast,
  output logic                                                 out_tvalid,
  input  logic                                                 out_tready,
  input  logic                                                 cfg_we,
  input  logic [CFG_ADDR_W-1:0]                                cfg_addr,
  input  logic [CFG_DATA_W-1:0]                                cfg_wdata
);

  localparam int ACC_W  = SAMPLE_WIDTH + MAX_LOG_POINTS;
  localparam int OUT_TW = ((2*ACC_W+7)/8)*8;

  r2fft_cmd_t              cmd;
  r2fft_sts_t              sts;
  logic signed [ACC_W-1:0] bin_real;
  logic signed [ACC_W-1:0] bin_imag;

  r2fft_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .sts       (sts),
    .cmd       (cmd)
  );

  r2fft_dp #(.SAMPLE_WIDTH(SAMPLE_WIDTH)) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .sts         (sts),
    .sample_real (in_tdata[SAMPLE_WIDTH-1:0]),
    .sample_imag (in_tdata[2*SAMPLE_WIDTH-1:SAMPLE_WIDTH]),
    .out_valid   (out_tvalid),
    .out_ready   (out_tready),
    .bin_real    (bin_real),
    .bin_imag    (bin_imag),
    .last_bin    (out_tlast)
  );

  // pack the bin, real part in the low bits, zero pad to whole bytes
  assign out_tdata = OUT_TW'({bin_imag, bin_real});

  // no sample lands while butterflies are still writing the buffers
  a_load_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |-> !sts.pipe_busy)
    else $error("sample accepted during transform");

  // the buffer ports serve one client at a time
  a_port_excl: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.bf_issue |-> !cmd.out_issue && !cmd.load_we)
    else $error("buffer port conflict");

  // a read-out is issued only with room in the output queue
  a_out_room: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_issue |-> sts.out_space)
    else $error("output queue overrun");

endmodule

/* bench/tb_top.sv */
`timescale 1ns / 1ps
module tb_top;
  import r2fft_pkg::*;

  localparam int SW  = 16;
  localparam int ACC = SW + MAX_LOG_POINTS;
  localparam int NPT = 1 << MAX_LOG_POINTS;

  logic        clk;
  logic        rst_n;
  // sample_real, sample_imag
  logic [31:0] in_tdata;
  logic        in_tvalid;
  logic        in_tready;
  // bin_real, bin_imag
  logic [47:0] out_tdata;
  logic        out_tlast;
  logic        out_tvalid;
  logic        out_tready;
  logic        cfg_we;
  logic [CFG_ADDR_W-1:0] cfg_addr;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  radix2_dif_fft_with_inverse #(.SAMPLE_WIDTH(SW)) dut (.*);

  // one expected frequency bin
  typedef struct {
    logic [ACC-1:0] re;
    logic [ACC-1:0] im;
    logic           last;
  } bin_t;

  // stimulus table row: a register write or one sample; chk rows type in bin 0
  typedef enum {ROW_CFG_INV, ROW_CFG_LOG, ROW_SAMPLE} row_kind_t;
  typedef struct {
    row_kind_t kind;
    int        a;
    int        b;
    bit        chk;
    int        exp_re;
    int        exp_im;
  } row_t;

  bin_t   bin_q[$];
  row_t   dir_tab[$];
  bit     failed;
  int     items;

  // predictor state
  longint frame_re [NPT];
  longint frame_im [NPT];
  int     fill_cnt;
  bit     inv_reg;
  int     log_reg;

  always begin
    clk = 1'b1; #6;
    clk = 1'b0; #6;
  end

  initial begin
    #20_000_000;
    $display("status: fail");
    $finish;
  end

  // receiver: alternate between always-ready stretches and random stalls
  int stall_phase = 0;
  always @(posedge clk) begin
    stall_phase <= stall_phase + 1;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (stall_phase[8]) begin
      out_tready <= 1'b1;
    end else begin
      out_tready <= ($urandom_range(0, 3) != 0);
    end
  end

  // check every accepted bin against the oldest expectation
  always @(posedge clk) begin
    bin_t e;
    if (rst_n && out_tvalid && out_tready) begin
      if (bin_q.size() == 0) begin
        $error("unexpected bin %h last %b", out_tdata, out_tlast);
        failed = 1'b1;
      end else begin
        e = bin_q.pop_front();
        if (out_tdata[ACC-1:0] !== e.re) begin
          $error("bin_real expected %h actual %h", e.re, out_tdata[ACC-1:0]);
          failed = 1'b1;
        end
        if (out_tdata[2*ACC-1:ACC] !== e.im) begin
          $error("bin_imag expected %h actual %h", e.im, out_tdata[2*ACC-1:ACC]);
          failed = 1'b1;
        end
        if (out_tlast !== e.last) begin
          $error("last_bin expected %b actual %b", e.last, out_tlast);
          failed = 1'b1;
        end
      end
    end
  end

  function automatic int eff_log();
    if (log_reg < 1) return 1;
    if (log_reg > MAX_LOG_POINTS) return MAX_LOG_POINTS;
    return log_reg;
  endfunction

  // floor((v + 2^(sh-1)) / 2^sh)
  function automatic longint round_shift(longint v, int sh);
    return (v + (64'sd1 <<< (sh - 1))) >>> sh;
  endfunction

  function automatic longint clamp_acc(longint v);
    longint lim;
    lim = 64'sd1 <<< (ACC - 1);
    if (v > lim - 1) return lim - 1;
    if (v < -lim) return -lim;
    return v;
  endfunction

  function automatic longint q15_of(longint unsigned v);
    longint unsigned q;
    q = (v + (64'd1 << 14)) >> 15;
    return (q > 32767) ? 32767 : longint'(q);
  endfunction

  // Q1.15 cos/sin of 2*pi*m/64 from an octant Taylor series in Q30
  task automatic rotor(input int m, output longint c, output longint s);
    longint unsigned one, phase, r, x, x2, ts, tc;
    longint          ss, cs, sm, cm;
    int              quad;
    bit              flip;
    one   = 64'd1 << 30;
    phase = (longint'(m) << (32 - MAX_LOG_POINTS)) & 64'hFFFF_FFFF;
    quad  = int'(phase >> 30);
    r     = phase & (one - 1);
    flip  = r > (one >> 1);
    if (flip) r = one - r;
    x  = (r * 64'd1686629713) >> 30;
    x2 = (x * x) >> 30;
    ts = x;
    tc = one;
    ss = longint'(x);
    cs = longint'(one);
    for (int n = 1; n <= 6; n++) begin
      ts = ((ts * x2) >> 30) / longint'((2 * n) * (2 * n + 1));
      tc = ((tc * x2) >> 30) / longint'((2 * n - 1) * (2 * n));
      if (n % 2) begin
        ss -= longint'(ts);
        cs -= longint'(tc);
      end else begin
        ss += longint'(ts);
        cs += longint'(tc);
      end
    end
    if (ss < 0) ss = 0;
    if (cs < 0) cs = 0;
    sm = q15_of(flip ? cs : ss);
    cm = q15_of(flip ? ss : cs);
    case (quad & 3)
      0: begin c = cm;  s = sm;  end
      1: begin c = -sm; s = cm;  end
      2: begin c = -cm; s = -sm; end
      default: begin c = sm; s = -cm; end
    endcase
  endtask

  // store one sample; on the last of a frame run the transform and queue all bins
  task automatic predict_sample(input logic [15:0] sr, input logic [15:0] si,
                                output int n_bins);
    longint sre [NPT];
    longint sim [NPT];
    longint dre [NPT];
    longint dim [NPT];
    longint wr, wi, dr, di, re, im;
    int     len, npts, span, half, p, rev;
    bin_t   b;
    len  = eff_log();
    npts = 1 << len;
    n_bins = 0;
    frame_re[fill_cnt % NPT] = longint'($signed(sr));
    frame_im[fill_cnt % NPT] = longint'($signed(si));
    fill_cnt++;
    if (fill_cnt < npts) return;
    fill_cnt = 0;
    sre = frame_re;
    sim = frame_im;
    for (int k = 0; k < len; k++) begin
      span = 1 << (len - k);
      half = span >> 1;
      for (int j = 0; j < (1 << k); j++) begin
        p = j * span;
        for (int i = 0; i < half; i++) begin
          rotor(((i << k) << (MAX_LOG_POINTS - len)) % NPT, wr, wi);
          if (!inv_reg) wi = -wi;
          dre[p+i] = clamp_acc(sre[p+i] + sre[p+i+half]);
          dim[p+i] = clamp_acc(sim[p+i] + sim[p+i+half]);
          dr = sre[p+i] - sre[p+i+half];
          di = sim[p+i] - sim[p+i+half];
          dre[p+i+half] = clamp_acc(round_shift(dr * wr - di * wi, 15));
          dim[p+i+half] = clamp_acc(round_shift(dr * wi + di * wr, 15));
        end
      end
      sre = dre;
      sim = dim;
    end
    // natural order out through a bit-reversed read
    for (int j = 0; j < npts; j++) begin
      rev = 0;
      for (int i = 0; i < len; i++)
        if (j & (1 << i)) rev |= 1 << (len - 1 - i);
      re = sre[rev];
      im = sim[rev];
      if (inv_reg) begin
        re = round_shift(re, len);
        im = round_shift(im, len);
      end
      b.re   = re[ACC-1:0];
      b.im   = im[ACC-1:0];
      b.last = (j == npts - 1);
      bin_q.insert(bin_q.size(), b);
    end
    n_bins = npts;
  endtask

  // hold the sample until accepted; then maybe drop valid for a random gap
  task automatic send_sample(input logic [15:0] sr, input logic [15:0] si,
                             output int n_bins);
    in_tdata  <= {si, sr};
    in_tvalid <= 1'b1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    items++;
    predict_sample(sr, si, n_bins);
    if ($urandom_range(0, 4) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
  endtask

  // write a register once the block has drained and settled
  task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx, input int val);
    in_tvalid <= 1'b0;
    while (bin_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val[CFG_DATA_W-1:0];
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_INVERSE_MODE) begin
      inv_reg = val[0];
    end else begin
      log_reg  = val & 7;
      fill_cnt = 0;
    end
  endtask

  function automatic logic [15:0] pick_value();
    case ($urandom_range(0, 7))
      0: return 16'h7FFF;
      1: return 16'h8000;
      default: return 16'($urandom());
    endcase
  endfunction

  initial begin
    bin_t     e;
    row_t     r;
    int       nb;
    int       len;
    int       npts;
    int       wait_cnt;
    logic [15:0] sr;
    logic [15:0] si;
    rst_n     = 1'b0;
    in_tdata  = '0;
    in_tvalid = 1'b0;
    cfg_we    = 1'b0;
    cfg_addr  = '0;
    cfg_wdata = '0;
    failed   = 1'b0;
    items    = 0;
    fill_cnt = 0;
    inv_reg  = 1'b0;
    log_reg  = 6;

    // directed part: length 2 frames typed in, extremes, clamped lengths, restart
    dir_tab = '{
      '{ROW_CFG_LOG, 1, 0, 0, 0, 0},
      '{ROW_SAMPLE, 100, -50, 0, 0, 0},
      '{ROW_SAMPLE, 100, -50, 1, 200, -100},
      '{ROW_SAMPLE, 32767, -32768, 0, 0, 0},
      '{ROW_SAMPLE, -32768, 32767, 0, 0, 0},
      '{ROW_CFG_INV, 1, 0, 0, 0, 0},
      '{ROW_SAMPLE, 1, 1, 0, 0, 0},
      '{ROW_SAMPLE, 1, 1, 1, 1, 1},
      '{ROW_SAMPLE, 32767, 32767, 0, 0, 0},
      '{ROW_SAMPLE, 32767, 32767, 1, 32767, 32767},
      '{ROW_CFG_LOG, 0, 0, 0, 0, 0},
      '{ROW_SAMPLE, -32768, -32768, 0, 0, 0},
      '{ROW_SAMPLE, 32767, 0, 0, 0, 0},
      '{ROW_CFG_INV, 0, 0, 0, 0, 0},
      '{ROW_CFG_LOG, 7, 0, 0, 0, 0},
      '{ROW_SAMPLE, 5, 6, 0, 0, 0},
      '{ROW_SAMPLE, 7, 8, 0, 0, 0},
      '{ROW_SAMPLE, -9, 3, 0, 0, 0},
      '{ROW_CFG_LOG, 2, 0, 0, 0, 0},
      '{ROW_SAMPLE, 32767, -32768, 0, 0, 0},
      '{ROW_SAMPLE, -32768, 32767, 0, 0, 0},
      '{ROW_SAMPLE, 32767, -32768, 0, 0, 0},
      '{ROW_SAMPLE, -32768, 32767, 0, 0, 0}
    };

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_tab[t]) begin
      r = dir_tab[t];
      case (r.kind)
        ROW_CFG_INV: write_reg(CFG_INVERSE_MODE, r.a);
        ROW_CFG_LOG: write_reg(CFG_LOG_POINTS, r.a);
        default: begin
          send_sample(16'(r.a), 16'(r.b), nb);
          // bin 0 of a typed frame replaces the computed one
          if (r.chk && nb > 0) begin
            e = bin_q[bin_q.size() - nb];
            e.re = ACC'(r.exp_re);
            e.im = ACC'(r.exp_im);
            bin_q[bin_q.size() - nb] = e;
          end
        end
      endcase
    end

    // random frames: mostly short lengths, some full length, some cut short
    while (items < 135) begin
      if ($urandom_range(0, 2) == 0) write_reg(CFG_INVERSE_MODE, $urandom_range(0, 1));
      len = ($urandom_range(0, 3) == 0) ? $urandom_range(6, 7) : $urandom_range(0, 5);
      write_reg(CFG_LOG_POINTS, len);
      npts = 1 << eff_log();
      if ($urandom_range(0, 5) == 0) begin
        // broken frame: a length write after 1 to npts samples drops any partial frame
        repeat ($urandom_range(1, npts)) begin
          send_sample(pick_value(), pick_value(), nb);
        end
        write_reg(CFG_LOG_POINTS, len);
      end
      for (int s = 0; s < npts; s++) begin
        sr = pick_value();
        si = pick_value();
        send_sample(sr, si, nb);
      end
    end

    in_tvalid <= 1'b0;
    wait_cnt = 0;
    while (bin_q.size() != 0 && wait_cnt < 200_000) begin
      @(posedge clk);
      wait_cnt++;
    end
    if (bin_q.size() != 0) begin
      $error("%0d bins never arrived", bin_q.size());
      failed = 1'b1;
    end
    repeat (50) @(posedge clk);
    if (!failed) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

/* radix2_dif_fft_with_inverse.f */
src/r2fft_pkg.sv
src/r2fft_ram.sv
src/r2fft_ctrl.sv
src/r2fft_dp.sv
src/radix2_dif_fft_with_inverse.sv
bench/tb_top.sv
